>>> hw/rtl/bmp_pkg.sv
// Shared types and constants for the bone matrix palette block.
`default_nettype none
package bmp_pkg;

  localparam logic [1:0] KIND_OFFSET  = 2'd0;
  localparam logic [1:0] KIND_LOCAL   = 2'd1;
  localparam logic [1:0] KIND_PARENT  = 2'd2;
  localparam logic [1:0] KIND_COMPUTE = 2'd3;

  localparam int unsigned LastIdx = 3;

  typedef logic [127:0] mrow_t;

  // Controller to datapath
  typedef struct packed {
    logic       issue;      // one MAC step enters the pipe
    logic       phase_b;    // 0: local * parent global, 1: offset * global
    logic [1:0] r;          // row being formed
    logic [1:0] k;          // inner-product term
    logic       latch_par;  // capture parent and root decision
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;  // addressed bone below the active count
    logic out_busy;  // output register still holds a row
  } dp_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/bmp_dp.sv
// Datapath: matrix stores, four MAC lanes, scratch matrix and output register.
`default_nettype none
module bmp_dp import bmp_pkg::*; #(
  parameter int unsigned MAX_BONES = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        acc_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [5:0]  bone_i,
  input  wire logic [1:0]  row_i,
  input  wire logic [6:0]  parent_i,
  input  wire mrow_t       elems_i,
  input  wire logic [8:0]  limit_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o,
  output logic [5:0]       out_bone_o,
  output logic [1:0]       out_row_o,
  output mrow_t            out_res_o,
  output logic             out_last_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);

  localparam int unsigned BW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int unsigned DEPTH = MAX_BONES * 4;
  localparam int unsigned ACC_W = 66 - FRAC_BITS;

  mrow_t      local_mem  [DEPTH];
  mrow_t      offset_mem [DEPTH];
  mrow_t      global_mem [DEPTH];
  logic [6:0] par_mem    [MAX_BONES];

  logic          wr_ok;
  logic [BW-1:0] in_idx;
  logic [BW-1:0] bone_q, pidx_q;
  logic [5:0]    bone6_q;
  logic          root_q;
  logic [6:0]    par_rd_q;
  mrow_t         loc_rd_q, off_rd_q, glb_rd_q;
  mrow_t         tmp_q [4];

  logic       v1_q, pb1_q, v2_q, pb2_q;
  logic [1:0] r1_q, k1_q, r2_q, k2_q;

  mrow_t              a_row, b_row;
  logic signed [31:0] a_sc;
  logic signed [63:0] prod_q [4];
  logic signed [ACC_W-1:0] acc_q [4];
  logic signed [ACC_W-1:0] sh [4];
  logic signed [ACC_W-1:0] sum [4];
  mrow_t              sat_row;
  logic               gw_en, res_load;

  logic       out_valid_q;
  logic [5:0] out_bone_q;
  logic [1:0] out_row_q;
  mrow_t      out_res_q;

  assign in_idx          = BW'(bone_i);
  assign sts_o.in_range  = ({3'b000, bone_i} < limit_i);
  assign sts_o.out_busy  = out_valid_q;
  assign wr_ok           = acc_i & sts_o.in_range;

  // Stores and their registered reads
  always_ff @(posedge clk_i) begin
    if (wr_ok && kind_i == KIND_OFFSET) begin
      offset_mem[{in_idx, row_i}] <= elems_i;
    end
    if (wr_ok && kind_i == KIND_LOCAL) begin
      local_mem[{in_idx, row_i}] <= elems_i;
    end
    if (wr_ok && kind_i == KIND_PARENT) begin
      par_mem[in_idx] <= parent_i;
    end
    if (gw_en) begin
      global_mem[{bone_q, k1_q}] <= b_row;
    end
    par_rd_q <= par_mem[in_idx];
    loc_rd_q <= local_mem[{bone_q, cmd_i.r}];
    off_rd_q <= offset_mem[{bone_q, cmd_i.r}];
    glb_rd_q <= global_mem[{pidx_q, cmd_i.k}];
  end

  // Bone and parent capture
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      bone_q  <= in_idx;
      bone6_q <= bone_i;
    end
    if (cmd_i.latch_par) begin
      root_q <= par_rd_q[6] | ({2'b00, par_rd_q} >= limit_i);
      pidx_q <= BW'(par_rd_q[5:0]);
    end
  end

  // Stage tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pb1_q <= cmd_i.phase_b;
    r1_q  <= cmd_i.r;
    k1_q  <= cmd_i.k;
    pb2_q <= pb1_q;
    r2_q  <= r1_q;
    k2_q  <= k1_q;
  end

  // Stage 1: operand select, multiply
  assign a_row = pb1_q ? off_rd_q : loc_rd_q;
  assign a_sc  = a_row[32*k1_q +: 32];
  assign b_row = pb1_q ? tmp_q[k1_q] : glb_rd_q;
  // new global goes to the store while the offset product reads it
  assign gw_en = v1_q & pb1_q & (r1_q == 2'd0);

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      prod_q[c] <= a_sc * $signed(b_row[32*c +: 32]);
    end
  end

  // Stage 2: floor shift, accumulate, saturate
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sh[c]  = ACC_W'(prod_q[c] >>> FRAC_BITS);
      sum[c] = ((k2_q == 2'd0) ? '0 : acc_q[c]) + sh[c];
      if (sum[c][ACC_W-1:31] == '0 || sum[c][ACC_W-1:31] == '1) begin
        sat_row[32*c +: 32] = sum[c][31:0];
      end else if (sum[c][ACC_W-1]) begin
        sat_row[32*c +: 32] = 32'h8000_0000;
      end else begin
        sat_row[32*c +: 32] = 32'h7fff_ffff;
      end
    end
  end

  assign res_load = v2_q & pb2_q & (k2_q == 2'(LastIdx));

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      acc_q[c] <= sum[c];
    end
    if (v1_q && !pb1_q && root_q) begin
      tmp_q[r1_q] <= loc_rd_q;
    end else if (v2_q && !pb2_q && !root_q && k2_q == 2'(LastIdx)) begin
      tmp_q[r2_q] <= sat_row;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_bone_q <= bone6_q;
      out_row_q  <= r2_q;
      out_res_q  <= sat_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_bone_o  = out_bone_q;
  assign out_row_o   = out_row_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = (out_row_q == 2'(LastIdx));

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !(out_valid_q && !out_ready_i))
    else $error("result row overwrote a pending output row");

endmodule
`default_nettype wire

>>> hw/rtl/bmp_ctrl.sv
// Controller: sequences parent lookup, global product and offset product.
`default_nettype none
module bmp_ctrl import bmp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic [1:0] kind_i,
  input  wire dp_sts_t    sts_i,
  output logic            ready_o,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SEL   = 9'b000000010,
    ST_RUNA  = 9'b000000100,
    ST_DRA1  = 9'b000001000,
    ST_DRA2  = 9'b000010000,
    ST_WAITB = 9'b000100000,
    ST_RUNB  = 9'b001000000,
    ST_DRB1  = 9'b010000000,
    ST_DRB2  = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;  // {row, term}

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (acc_i && kind_i == KIND_COMPUTE && sts_i.in_range) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL:  state_d = ST_RUNA;
      ST_RUNA: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'hf) begin
          state_d = ST_DRA1;
        end
      end
      ST_DRA1: state_d = ST_DRA2;
      ST_DRA2: state_d = ST_WAITB;
      ST_WAITB: begin
        if (!sts_i.out_busy) begin
          state_d = ST_RUNB;
        end
      end
      ST_RUNB: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q[1:0] == 2'(LastIdx)) begin
          state_d = ST_DRB1;
        end
      end
      ST_DRB1: state_d = ST_DRB2;
      ST_DRB2: state_d = (cnt_q == 4'h0) ? ST_IDLE : ST_WAITB;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign ready_o           = (state_q == ST_IDLE);
  assign cmd_o.issue       = (state_q == ST_RUNA) | (state_q == ST_RUNB);
  assign cmd_o.phase_b     = (state_q == ST_RUNB);
  assign cmd_o.r           = cnt_q[3:2];
  assign cmd_o.k           = cnt_q[1:0];
  assign cmd_o.latch_par   = (state_q == ST_SEL);

  a_runb_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUNB && cnt_q[1:0] == 2'd0) |-> $past(state_q) == ST_WAITB)
    else $error("offset row started without waiting for the output register");

endmodule
`default_nettype wire

>>> hw/rtl/bone_matrix_palette_core.sv
// Top level of the bone matrix palette: stream ports, bone count register.
`default_nettype none
// Forward-kinematics matrix palette in signed Q16.16. Row items (offset or
// local pose) and parent items are stored in the accept cycle, so they can
// follow each other back to back. A compute item keeps the input stalled
// until its last offset row has gone through the pipe. The stall covers
// parent lookup, 16 steps of the four-lane MAC pipe for local * parent
// global (also for a root, which copies the local rows), a pipe drain, then
// four offset rows of 4 steps plus a pipe drain each. Each offset row starts
// only after the wait state sees the output register empty; for every row
// but the first, the row before is still in the register when that check
// begins. Receiver stalls lengthen the wait. The single output register and
// the three-stage MAC pipe (store read, multiply, accumulate) set the length
// of the stall. Items for bones at or above the bone count are dropped.
// Parents must be computed before their children; stores hold garbage until
// written and need no clearing after reset.
module bone_matrix_palette_core import bmp_pkg::*; #(
  parameter int unsigned MAX_BONES = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [6:0]   cfg_wdata_i,      // bone_count
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // bone[5:0] row[7:6] parent[14:8] elem0[46:15] elem1[78:47]
  // elem2[110:79] elem3[142:111] zero[143]
  input  wire logic [143:0] s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,     // kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_bone[5:0] out_row[7:6] res0[39:8] res1[71:40] res2[103:72]
  // res3[135:104]
  output logic [135:0]      m_axis_tdata,
  output logic              m_axis_tlast      // last_row
);

  logic [6:0] bone_count_q;
  logic [8:0] limit;
  logic       acc;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [5:0] out_bone;
  logic [1:0] out_row;
  mrow_t      out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bone_count_q <= '0;
    end else if (cfg_we_i) begin
      bone_count_q <= cfg_wdata_i;
    end
  end

  // Effective count is clamped to the store depth
  assign limit = ({2'b00, bone_count_q} > 9'(MAX_BONES)) ? 9'(MAX_BONES)
                                                         : {2'b00, bone_count_q};
  assign acc   = s_axis_tvalid & s_axis_tready;

  bmp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .kind_i  (s_axis_tuser),
    .sts_i   (sts),
    .ready_o (s_axis_tready),
    .cmd_o   (cmd)
  );

  bmp_dp #(
    .MAX_BONES (MAX_BONES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .kind_i      (s_axis_tuser),
    .bone_i      (s_axis_tdata[5:0]),
    .row_i       (s_axis_tdata[7:6]),
    .parent_i    (s_axis_tdata[14:8]),
    .elems_i     (s_axis_tdata[142:15]),
    .limit_i     (limit),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_bone_o  (out_bone),
    .out_row_o   (out_row),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {out_res, out_row, out_bone};

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[7:6] == 2'(LastIdx))
    else $error("tlast on a row other than the fourth");

endmodule
`default_nettype wire
